// ===== rtl/tcab_pkg.sv =====
// ----------------------------------------------------------------------------
// tcab_pkg
// Shared types, constants and helpers for the text coverage alpha blender.
// ----------------------------------------------------------------------------
package tcab_pkg;

	typedef enum logic [1:0] {
		MODE_RGB565 = 2'd0,
		MODE_RGB555 = 2'd1,
		MODE_RGB888 = 2'd2,
		MODE_MONO   = 2'd3
	} pix_mode_t;

	localparam logic CFG_PIXEL_MODE = 1'b0;
	localparam logic CFG_TEXT_COLOR = 1'b1;

	localparam int COV_W  = 3;
	localparam int PIX_W  = 32;
	localparam int CHAN_W = 8;
	localparam int PROD_W = 17;
	localparam int NCHAN  = 3;

	localparam logic [COV_W-1:0]  COV_FULL    = 3'd4;
	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hff;

	typedef logic [CHAN_W-1:0] chan_t;

	// side data that rides along the datapath
	typedef struct packed {
		logic             we;
		logic             replace;
		logic [PIX_W-1:0] pix;
	} side_t;

	function automatic chan_t alpha_of(input logic [COV_W-1:0] cov);
		logic [COV_W-1:0] c;
		chan_t            a;
		c = (cov > COV_FULL) ? COV_FULL : cov;
		unique case (c)
			3'd0:    a = 8'd0;
			3'd1:    a = 8'd64;
			3'd2:    a = 8'd128;
			3'd3:    a = 8'd192;
			default: a = ALPHA_OPAQUE;
		endcase
		return a;
	endfunction

endpackage

// ===== rtl/text_coverage_alpha_blend_top.sv =====
// Path: an accepted input passes through the unpack, multiply, round and pack
// registers in order before it is offered on the output; a stall can hold it in any stage.
// Throughput: one pixel per cycle; four register stages (unpack, multiply,
// round, pack), each stage advances when empty or when the next one advances.
// Reset: arst_n clears all stage valid bits and sets pixel_mode and
// text_color to zero.
// ----------------------------------------------------------------------------
// text_coverage_alpha_blend_top
// Blends a text color into destination pixels by glyph coverage level.
// ----------------------------------------------------------------------------
module text_coverage_alpha_blend_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [31:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // [2:0] coverage, [34:3] dest_pixel, [39:35] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata    // [0] write_enable, [32:1] new_pixel, [39:33] zero
);

	tcab_pkg::pix_mode_t        mode_q;
	logic [tcab_pkg::PIX_W-1:0] color_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	tcab_pkg::side_t                       side_s1, side_s2, side_s3;
	tcab_pkg::chan_t                       alpha_s1;
	tcab_pkg::chan_t [tcab_pkg::NCHAN-1:0] col_s1, dst_s1, blend_s3;
	logic                                  we_s4;
	logic [tcab_pkg::PIX_W-1:0]            pix_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= tcab_pkg::MODE_RGB565;
			color_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				tcab_pkg::CFG_PIXEL_MODE: mode_q  <= tcab_pkg::pix_mode_t'(cfg_wdata[1:0]);
				tcab_pkg::CFG_TEXT_COLOR: color_q <= cfg_wdata;
			endcase
		end
	end

	assign en4 = !v_s4 || m_axis_tready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) side_s2 <= side_s1;
		if (en3) side_s3 <= side_s2;
	end

	tcab_unpack u_unpack (
		.clk        (clk),
		.en         (en1),
		.mode       (mode_q),
		.color      (color_q),
		.coverage   (s_axis_tdata[2:0]),
		.dest_pixel (s_axis_tdata[34:3]),
		.side_s1    (side_s1),
		.alpha_s1   (alpha_s1),
		.col_s1     (col_s1),
		.dst_s1     (dst_s1)
	);

	for (genvar i = 0; i < tcab_pkg::NCHAN; i++) begin : g_chan
		tcab_blend_chan u_chan (
			.clk      (clk),
			.en2      (en2),
			.en3      (en3),
			.col      (col_s1[i]),
			.dst      (dst_s1[i]),
			.alpha    (alpha_s1),
			.blend_s3 (blend_s3[i])
		);
	end

	tcab_pack u_pack (
		.clk    (clk),
		.en     (en4),
		.mode   (mode_q),
		.side   (side_s3),
		.blend  (blend_s3),
		.we_s4  (we_s4),
		.pix_s4 (pix_s4)
	);

	assign s_axis_tready = en1;
	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = {7'd0, pix_s4, we_s4};

endmodule

// ===== rtl/tcab_unpack.sv =====
// ----------------------------------------------------------------------------
// tcab_unpack
// Stage 1: coverage to alpha, write/replace decision, channel unpacking.
// ----------------------------------------------------------------------------
module tcab_unpack (
	input  logic                                        clk,
	input  logic                                        en,
	input  tcab_pkg::pix_mode_t                         mode,
	input  logic [tcab_pkg::PIX_W-1:0]                  color,
	input  logic [tcab_pkg::COV_W-1:0]                  coverage,
	input  logic [tcab_pkg::PIX_W-1:0]                  dest_pixel,
	output tcab_pkg::side_t                             side_s1,
	output tcab_pkg::chan_t                             alpha_s1,
	output tcab_pkg::chan_t [tcab_pkg::NCHAN-1:0]       col_s1,
	output tcab_pkg::chan_t [tcab_pkg::NCHAN-1:0]       dst_s1
);

	tcab_pkg::chan_t                       alpha;
	tcab_pkg::side_t                       side;
	tcab_pkg::chan_t [tcab_pkg::NCHAN-1:0] col_u;
	tcab_pkg::chan_t [tcab_pkg::NCHAN-1:0] dst_u;

	// channel order: [2] red, [1] green, [0] blue
	always_comb begin
		alpha        = tcab_pkg::alpha_of(coverage);
		side.we      = (alpha != 8'd0);
		// zero coverage keeps the destination pixel, even in mono mode
		side.replace = side.we && ((mode == tcab_pkg::MODE_MONO) ||
			(alpha == tcab_pkg::ALPHA_OPAQUE));
		side.pix     = side.replace ? color : dest_pixel;
		unique case (mode)
			tcab_pkg::MODE_RGB565: begin
				col_u[2] = {color[15:11], 3'b000};
				col_u[1] = {color[10:5], 2'b00};
				col_u[0] = {color[4:0], 3'b000};
				dst_u[2] = {dest_pixel[15:11], 3'b000};
				dst_u[1] = {dest_pixel[10:5], 2'b00};
				dst_u[0] = {dest_pixel[4:0], 3'b000};
			end
			tcab_pkg::MODE_RGB555: begin
				col_u[2] = {color[14:10], 3'b000};
				col_u[1] = {color[9:5], 3'b000};
				col_u[0] = {color[4:0], 3'b000};
				dst_u[2] = {dest_pixel[14:10], 3'b000};
				dst_u[1] = {dest_pixel[9:5], 3'b000};
				dst_u[0] = {dest_pixel[4:0], 3'b000};
			end
			tcab_pkg::MODE_RGB888, tcab_pkg::MODE_MONO: begin
				col_u[2] = color[23:16];
				col_u[1] = color[15:8];
				col_u[0] = color[7:0];
				dst_u[2] = dest_pixel[23:16];
				dst_u[1] = dest_pixel[15:8];
				dst_u[0] = dest_pixel[7:0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1  <= side;
			alpha_s1 <= alpha;
			col_s1   <= col_u;
			dst_s1   <= dst_u;
		end
	end

endmodule

// ===== rtl/tcab_blend_chan.sv =====
// ----------------------------------------------------------------------------
// tcab_blend_chan
// One channel: stage 2 multiplies (c - p) by alpha, stage 3 rounds and adds p.
// ----------------------------------------------------------------------------
module tcab_blend_chan (
	input  logic            clk,
	input  logic            en2,
	input  logic            en3,
	input  tcab_pkg::chan_t col,
	input  tcab_pkg::chan_t dst,
	input  tcab_pkg::chan_t alpha,
	output tcab_pkg::chan_t blend_s3
);

	logic signed [tcab_pkg::CHAN_W:0]   diff;
	logic signed [tcab_pkg::PROD_W-1:0] prod_s2;
	tcab_pkg::chan_t                    dst_s2;
	logic signed [tcab_pkg::PROD_W:0]   prod_x;
	logic signed [tcab_pkg::PROD_W:0]   rsum;

	assign diff = $signed({1'b0, col}) - $signed({1'b0, dst});

	always_ff @(posedge clk) begin
		if (en2) begin
			prod_s2 <= tcab_pkg::PROD_W'(diff * $signed({1'b0, alpha}));
			dst_s2  <= dst;
		end
	end

	// t + (t >>> 8) + 0x80, then >>> 8; only the low 8 bits survive the add
	assign prod_x = {prod_s2[tcab_pkg::PROD_W-1], prod_s2};
	assign rsum   = prod_x + (prod_x >>> 8) + 18'sd128;

	always_ff @(posedge clk) begin
		if (en3) begin
			blend_s3 <= dst_s2 + rsum[15:8];
		end
	end

endmodule

// ===== rtl/tcab_pack.sv =====
// ----------------------------------------------------------------------------
// tcab_pack
// Stage 4: repacks blended channels and selects the final pixel.
// ----------------------------------------------------------------------------
module tcab_pack (
	input  logic                                  clk,
	input  logic                                  en,
	input  tcab_pkg::pix_mode_t                   mode,
	input  tcab_pkg::side_t                       side,
	input  tcab_pkg::chan_t [tcab_pkg::NCHAN-1:0] blend,
	output logic                                  we_s4,
	output logic [tcab_pkg::PIX_W-1:0]            pix_s4
);

	logic [tcab_pkg::PIX_W-1:0] packed_pix;

	always_comb begin
		unique case (mode)
			tcab_pkg::MODE_RGB565:
				packed_pix = {16'd0, blend[2][7:3], blend[1][7:2], blend[0][7:3]};
			tcab_pkg::MODE_RGB555:
				packed_pix = {17'd0, blend[2][7:3], blend[1][7:3], blend[0][7:3]};
			tcab_pkg::MODE_RGB888, tcab_pkg::MODE_MONO:
				packed_pix = {8'd0, blend[2], blend[1], blend[0]};
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			we_s4  <= side.we;
			pix_s4 <= (side.we && !side.replace) ? packed_pix : side.pix;
		end
	end

endmodule

// ===== sim/tb_text_coverage_alpha_blend_top.sv =====
// ----------------------------------------------------------------------------
// tb_text_coverage_alpha_blend_top
// Self-checking bench for the text coverage alpha blender. Pixels are streamed
// under each color mode and text color, with random gaps on both sides and a
// long output stall. Every output transfer is compared against an in-bench
// blend of coverage, destination pixel and the current register settings.
// ----------------------------------------------------------------------------
module tb_text_coverage_alpha_blend_top;

	localparam int IDLE_LIMIT = 3000;
	localparam int LONG_HOLD  = 120;

	typedef struct packed {
		logic [2:0]  cov;
		logic [31:0] dest;
	} glyph_px_t;

	typedef struct packed {
		logic        we;
		logic [31:0] pix;
	} blend_res_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_addr;
	logic [31:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;   // [2:0] coverage, [34:3] dest_pixel, [39:35] zero
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // [0] write_enable, [32:1] new_pixel, [39:33] zero

	glyph_px_t           pixel_q[$];
	blend_res_t          blend_q[$];
	tcab_pkg::pix_mode_t cur_mode;
	logic [31:0]         cur_color;
	int                  mismatches;
	int                  idle_cycles;
	int                  tx_gap;
	int                  rx_stall;
	logic                in_took;
	logic                no_gaps;
	logic                long_hold_req;

	text_coverage_alpha_blend_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int mix_chan(input int c, input int p, input int a);
		int t;
		int q;
		t = (c - p) * a;
		q = (t + (t >>> 8) + 128) >>> 8;
		return (p + q) & 255;
	endfunction

	function automatic blend_res_t blend_pixel(input logic [2:0] cov, input logic [31:0] dst);
		blend_res_t  res;
		int          a;
		int          cr, cg, cb, r, g, b;
		logic [7:0]  nr, ng, nb;
		logic [31:0] col;
		col = cur_color;
		case (cov)
			3'd0:    a = 0;
			3'd1:    a = 64;
			3'd2:    a = 128;
			3'd3:    a = 192;
			default: a = 255;
		endcase
		res.we  = 1'b0;
		res.pix = dst;
		if (a == 0) begin
			res.we = 1'b0;
		end else if (cur_mode == tcab_pkg::MODE_MONO || a == 255) begin
			res.we  = 1'b1;
			res.pix = col;
		end else begin
			res.we = 1'b1;
			case (cur_mode)
				tcab_pkg::MODE_RGB565: begin
					cr = int'({col[15:11], 3'b0});
					cg = int'({col[10:5], 2'b0});
					cb = int'({col[4:0], 3'b0});
					r  = int'({dst[15:11], 3'b0});
					g  = int'({dst[10:5], 2'b0});
					b  = int'({dst[4:0], 3'b0});
				end
				tcab_pkg::MODE_RGB555: begin
					cr = int'({col[14:10], 3'b0});
					cg = int'({col[9:5], 3'b0});
					cb = int'({col[4:0], 3'b0});
					r  = int'({dst[14:10], 3'b0});
					g  = int'({dst[9:5], 3'b0});
					b  = int'({dst[4:0], 3'b0});
				end
				default: begin
					cr = int'(col[23:16]); cg = int'(col[15:8]); cb = int'(col[7:0]);
					r  = int'(dst[23:16]); g  = int'(dst[15:8]); b  = int'(dst[7:0]);
				end
			endcase
			nr = 8'(mix_chan(cr, r, a));
			ng = 8'(mix_chan(cg, g, a));
			nb = 8'(mix_chan(cb, b, a));
			case (cur_mode)
				tcab_pkg::MODE_RGB565: res.pix = {16'b0, nr[7:3], ng[7:2], nb[7:3]};
				tcab_pkg::MODE_RGB555: res.pix = {17'b0, nr[7:3], ng[7:3], nb[7:3]};
				default:               res.pix = {8'b0, nr, ng, nb};
			endcase
		end
		return res;
	endfunction

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps)
			return 0;
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// pixel source
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (s_axis_tvalid && !in_took) begin
			s_axis_tvalid <= 1'b1;
		end else if (tx_gap > 0) begin
			s_axis_tvalid <= 1'b0;
			tx_gap        <= tx_gap - 1;
		end else if (pixel_q.size() > 0) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= {5'b0, pixel_q[0].dest, pixel_q[0].cov};
			tx_gap        <= gap_len();
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// result sink
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (rx_stall > 0) begin
			m_axis_tready <= 1'b0;
			rx_stall      <= rx_stall - 1;
		end else if (long_hold_req) begin
			m_axis_tready <= 1'b0;
			rx_stall      <= LONG_HOLD - 1;
			long_hold_req <= 1'b0;
		end else begin
			int g;
			g = gap_len();
			m_axis_tready <= (g == 0);
			if (g > 0)
				rx_stall <= g - 1;
		end
	end

	// transfer monitor and checker
	always @(posedge clk) begin
		in_took <= s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			blend_q.push_back(blend_pixel(s_axis_tdata[2:0], s_axis_tdata[34:3]));
			void'(pixel_q.pop_front());
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (blend_q.size() == 0) begin
				$error("unexpected result transfer: write_enable %0b new_pixel %08h",
					m_axis_tdata[0], m_axis_tdata[32:1]);
				mismatches++;
			end else begin
				blend_res_t exp_res;
				exp_res = blend_q.pop_front();
				if (m_axis_tdata[0] !== exp_res.we) begin
					$error("write_enable: expected %0b, actual %0b", exp_res.we, m_axis_tdata[0]);
					mismatches++;
				end
				if (m_axis_tdata[32:1] !== exp_res.pix) begin
					$error("new_pixel: expected %08h, actual %08h", exp_res.pix,
						m_axis_tdata[32:1]);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_axis_tvalid && s_axis_tready)
				|| (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL text_coverage_alpha_blend_top");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_reg(input logic idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == tcab_pkg::CFG_PIXEL_MODE)
			cur_mode = tcab_pkg::pix_mode_t'(value[1:0]);
		else
			cur_color = value;
	endtask

	task automatic set_mode(input tcab_pkg::pix_mode_t mode);
		write_reg(tcab_pkg::CFG_PIXEL_MODE, ($urandom & ~32'h3) | 32'(mode));
	endtask

	task automatic queue_px(input logic [2:0] cov, input logic [31:0] dest);
		glyph_px_t px;
		px.cov  = cov;
		px.dest = dest;
		pixel_q.push_back(px);
	endtask

	task automatic wait_drained();
		while (pixel_q.size() != 0 || blend_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_addr      = tcab_pkg::CFG_PIXEL_MODE;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cur_mode      = tcab_pkg::MODE_RGB565;
		cur_color     = '0;
		mismatches    = 0;
		idle_cycles   = 0;
		tx_gap        = 0;
		rx_stall      = 0;
		in_took       = 1'b0;
		no_gaps       = 1'b0;
		long_hold_req = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: every coverage level, saturation included
		@(posedge clk);
		for (int c = 0; c < 8; c++)
			queue_px(3'(c), 32'hffff_ffff);
		wait_drained();

		set_mode(tcab_pkg::MODE_RGB565);
		write_reg(tcab_pkg::CFG_TEXT_COLOR, 32'hffff_ffff);
		@(posedge clk);
		queue_px(3'd1, 32'h0000_0000);
		queue_px(3'd2, 32'h0000_0000);
		queue_px(3'd3, 32'h0000_0000);
		queue_px(3'd4, 32'h1234_abcd);
		queue_px(3'd0, 32'hdead_beef);
		wait_drained();

		set_mode(tcab_pkg::MODE_RGB555);
		write_reg(tcab_pkg::CFG_TEXT_COLOR, 32'h0000_7fff);
		@(posedge clk);
		queue_px(3'd1, 32'hffff_0000);
		queue_px(3'd3, 32'hffff_0000);
		wait_drained();

		set_mode(tcab_pkg::MODE_RGB888);
		write_reg(tcab_pkg::CFG_TEXT_COLOR, 32'h00ff_ffff);
		@(posedge clk);
		queue_px(3'd2, 32'h0000_0000);
		queue_px(3'd3, 32'hff00_0000);
		wait_drained();

		write_reg(tcab_pkg::CFG_TEXT_COLOR, 32'h0000_0000);
		@(posedge clk);
		queue_px(3'd1, 32'hffff_ffff);
		wait_drained();

		set_mode(tcab_pkg::MODE_MONO);
		write_reg(tcab_pkg::CFG_TEXT_COLOR, 32'ha5a5_a5a5);
		@(posedge clk);
		queue_px(3'd0, 32'h5a5a_5a5a);
		queue_px(3'd1, 32'h5a5a_5a5a);
		queue_px(3'd7, 32'h5a5a_5a5a);
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			logic [31:0] color;
			if (ph < 4)
				set_mode(tcab_pkg::pix_mode_t'(ph));
			else
				set_mode(tcab_pkg::pix_mode_t'($urandom_range(0, 3)));
			if (ph == 1)
				color = 32'hffff_ffff;
			else if (ph == 2)
				color = 32'h0000_0000;
			else
				color = $urandom;
			write_reg(tcab_pkg::CFG_TEXT_COLOR, color);
			no_gaps = (ph == 2);
			@(posedge clk);
			for (int i = 0; i < 48; i++) begin
				int          r;
				logic [31:0] dest;
				r = $urandom_range(0, 9);
				if (r == 0)
					dest = 32'h0000_0000;
				else if (r == 1)
					dest = 32'hffff_ffff;
				else
					dest = $urandom;
				queue_px(3'($urandom_range(0, 7)), dest);
			end
			if (ph == 4)
				long_hold_req = 1'b1;
			wait_drained();
		end
		no_gaps = 1'b0;

		repeat (20) @(posedge clk);
		if (mismatches == 0 && blend_q.size() == 0)
			$display("PASS text_coverage_alpha_blend_top");
		else
			$display("FAIL text_coverage_alpha_blend_top");
		$finish;
	end

endmodule
